>>> hw/rtl/huffman_code_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shorthand for the concurrent checks at the end of the packer modules.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HCBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hcbp_pkg.sv
// ---------------------------------------------------------------------------
// Huffman code bit packer package
// Widths, function codes and the structs passed between the packer modules.
// ---------------------------------------------------------------------------
package hcbp_pkg;

   localparam int BYTE_W          = 8;
   localparam int SYM_W           = 8;
   localparam int CODE_W          = 32;
   localparam int LEN_W           = 6;
   localparam int PEND_W          = 3;
   localparam int TAKE_W          = 4;
   localparam int SYMBOL_COUNT    = 256;
   localparam int MAX_CODE_LENGTH = 32;

   // longest code the table keeps: the tighter of the limit and the word
   localparam int MAX_LEN = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ENCODE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;

   // packer state seen by the shift unit
   typedef struct packed {
      logic [BYTE_W-1:0] acc;      // pending bits, right-aligned
      logic [PEND_W-1:0] pending;  // count of pending bits
      logic [CODE_W-1:0] code;     // remaining code bits, left-aligned
      logic [LEN_W-1:0]  rem;      // count of remaining code bits
   } hcbp_pack_type;

   // one step of the shift unit
   typedef struct packed {
      logic [BYTE_W-1:0] acc;
      logic [PEND_W-1:0] pending;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  rem;
      logic [BYTE_W-1:0] byte_out;
      logic              emit;     // a full byte is ready
      logic              last;     // no further byte from this code
      logic              done;     // code exhausted
   } hcbp_step_type;

endpackage

>>> hw/rtl/hcbp_code_table.sv
// ---------------------------------------------------------------------------
// Huffman code table
// Per-symbol code store; lengths are saturated and codes left-aligned on write.
// ---------------------------------------------------------------------------
module hcbp_code_table (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [hcbp_pkg::SYM_W-1:0]  wr_addr,
   input  logic [hcbp_pkg::CODE_W-1:0] wr_code,
   input  logic [hcbp_pkg::LEN_W-1:0]  wr_len,
   input  logic                        rd_en,
   input  logic [hcbp_pkg::SYM_W-1:0]  rd_addr,
   output logic [hcbp_pkg::CODE_W-1:0] rd_code,
   output logic [hcbp_pkg::LEN_W-1:0]  rd_len
);

   localparam logic [hcbp_pkg::LEN_W-1:0] MaxLen  = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_LEN);
   localparam logic [hcbp_pkg::LEN_W-1:0] CodeLen = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W);

   typedef struct packed {
      logic [hcbp_pkg::CODE_W-1:0] code;
      logic [hcbp_pkg::LEN_W-1:0]  len;
   } entry_type;

   entry_type mem [hcbp_pkg::SYMBOL_COUNT];
   entry_type wr_entry;
   entry_type rd_entry_ff;
   logic [hcbp_pkg::LEN_W-1:0] len_sat;

   // clamp the length; the left shift drops the bits above it
   always_comb begin
      len_sat       = (wr_len > MaxLen) ? MaxLen : wr_len;
      wr_entry.len  = len_sat;
      wr_entry.code = wr_code << (CodeLen - len_sat);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_code = rd_entry_ff.code;
   assign rd_len  = rd_entry_ff.len;

endmodule

>>> hw/rtl/hcbp_shift_unit.sv
// ---------------------------------------------------------------------------
// Huffman shift-merge unit
// Moves up to one byte of code bits into the accumulator per step.
// ---------------------------------------------------------------------------
module hcbp_shift_unit (
   input  hcbp_pkg::hcbp_pack_type cur,
   output hcbp_pkg::hcbp_step_type nxt
);

   localparam logic [hcbp_pkg::TAKE_W-1:0] ByteBits = hcbp_pkg::TAKE_W'(hcbp_pkg::BYTE_W);

   logic [hcbp_pkg::TAKE_W-1:0]   space;
   logic [hcbp_pkg::TAKE_W-1:0]   take;
   logic [hcbp_pkg::TAKE_W-1:0]   sum;
   logic [2*hcbp_pkg::BYTE_W-1:0] merged;
   logic [hcbp_pkg::BYTE_W-1:0]   top_bits;
   logic [hcbp_pkg::LEN_W-1:0]    rem_next;

   always_comb begin
      space    = ByteBits - {1'b0, cur.pending};
      take     = (cur.rem < {2'b0, space}) ? cur.rem[hcbp_pkg::TAKE_W-1:0] : space;
      top_bits = cur.code[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W];
      merged   = ({{hcbp_pkg::BYTE_W{1'b0}}, cur.acc} << take)
               | ({{hcbp_pkg::BYTE_W{1'b0}}, top_bits} >> (ByteBits - take));
      sum      = {1'b0, cur.pending} + take;
      rem_next = cur.rem - {2'b0, take};

      nxt.byte_out = merged[hcbp_pkg::BYTE_W-1:0];
      nxt.emit     = (sum == ByteBits);
      // clear the accumulator once a byte leaves
      nxt.acc      = nxt.emit ? '0 : merged[hcbp_pkg::BYTE_W-1:0];
      nxt.pending  = nxt.emit ? '0 : sum[hcbp_pkg::PEND_W-1:0];
      nxt.code     = cur.code << take;
      nxt.rem      = rem_next;
      nxt.last     = (rem_next < {2'b0, ByteBits});
      nxt.done     = (rem_next == '0);
   end

endmodule

>>> hw/rtl/huffman_code_bit_packer.sv
// ---------------------------------------------------------------------------
// Huffman code bit packer
// Table-driven Huffman encoder packing code bits into bytes, earliest first.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. req_func selects load (write the code of req_symbol from
//   req_code_word / req_code_length), encode (append the code of req_symbol)
//   or flush (pad pending bits with zeros and send them).
//   Result channel: rsp_valid marks each byte for exactly one cycle;
//   rsp_last flags the final byte of a command. The receiver cannot stall,
//   so every byte must be taken in the cycle it is shown.
//   Load: busy stays low; no result.
//   Flush: busy stays low; a byte, if bits were pending, appears the next cycle.
//   Encode: busy for the registered table read (LOOKUP) and then for the merge
//   steps (SHIFT), where a step ends at a byte boundary or at the end of the
//   code; a zero-length code ends after the table read. Bytes come one per
//   cycle. Each merge step is done by the byte-wide shift-merge unit.
//   Reset clears the accumulator and the sequencer; the code table holds
//   nothing valid until loaded, and only loaded symbols may be encoded.
// ---------------------------------------------------------------------------
`include "huffman_code_bit_packer_assert.svh"

module huffman_code_bit_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [hcbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]  req_code_word,
   input  logic [hcbp_pkg::LEN_W-1:0]   req_code_length,
   output logic                         rsp_valid,
   output logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_last
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [hcbp_pkg::BYTE_W-1:0] acc_ff, acc_in;
   logic [hcbp_pkg::PEND_W-1:0] pending_ff, pending_in;
   logic [hcbp_pkg::CODE_W-1:0] code_ff, code_in;
   logic [hcbp_pkg::LEN_W-1:0]  rem_ff, rem_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic [hcbp_pkg::CODE_W-1:0] rd_code;
   logic [hcbp_pkg::LEN_W-1:0]  rd_len;
   hcbp_pkg::hcbp_pack_type cur;
   hcbp_pkg::hcbp_step_type step;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // code store: load writes at acceptance, encode reads the symbol's entry
   hcbp_code_table u_table (
      .clock   (clock),
      .wr_en   (accept && (req_func == hcbp_pkg::FUNC_LOAD)),
      .wr_addr (req_symbol),
      .wr_code (req_code_word),
      .wr_len  (req_code_length),
      .rd_en   (accept && (req_func == hcbp_pkg::FUNC_ENCODE)),
      .rd_addr (req_symbol),
      .rd_code (rd_code),
      .rd_len  (rd_len)
   );

   // shared shift-merge unit, reused on every step of an encode
   always_comb begin
      cur.acc     = acc_ff;
      cur.pending = pending_ff;
      cur.code    = code_ff;
      cur.rem     = rem_ff;
   end

   hcbp_shift_unit u_shift (
      .cur (cur),
      .nxt (step)
   );

   always_comb begin
      state_in        = state_ff;
      acc_in          = acc_ff;
      pending_in      = pending_ff;
      code_in         = code_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = 1'b0;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_func == hcbp_pkg::FUNC_ENCODE) begin
                  state_in = ST_LOOKUP;
               end else if (req_func == hcbp_pkg::FUNC_FLUSH) begin
                  // pad at the low end and send; drop the command when empty
                  if (pending_ff != '0) begin
                     rsp_valid_in    = 1'b1;
                     rsp_out_byte_in = acc_ff << (hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_W)
                                                  - pending_ff);
                     rsp_last_in     = 1'b1;
                     acc_in          = '0;
                     pending_in      = '0;
                  end
               end else begin
                  // load goes straight to the table; unused codes are dropped
               end
            end
         end
         ST_LOOKUP: begin
            // a zero-length code sends nothing
            code_in  = rd_code;
            rem_in   = rd_len;
            state_in = (rd_len == '0) ? ST_IDLE : ST_SHIFT;
         end
         ST_SHIFT: begin
            acc_in     = step.acc;
            pending_in = step.pending;
            code_in    = step.code;
            rem_in     = step.rem;
            if (step.emit) begin
               rsp_valid_in    = 1'b1;
               rsp_out_byte_in = step.byte_out;
               rsp_last_in     = step.last;
            end
            if (step.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      code_ff         <= code_in;
      rem_ff          <= rem_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // every byte sent leaves an empty accumulator behind
   `HCBP_ASSERT_NOW(a_sent_clears_acc, clock, reset, rsp_valid_ff, (pending_ff == '0) && (acc_ff == '0), "accumulator not cleared after byte")
   // the merge loop runs only while code bits remain
   `HCBP_ASSERT_NOW(a_shift_has_bits, clock, reset, state_ff == ST_SHIFT, rem_ff != '0, "merge step with no code bits left")
   // a flush with pending bits sends one final byte next cycle
   `HCBP_ASSERT_NEXT(a_flush_sends, clock, reset, accept && (req_func == hcbp_pkg::FUNC_FLUSH) && (pending_ff != '0), rsp_valid_ff && rsp_last_ff && (pending_ff == '0), "flush byte missing")
   // a load never makes the block busy
   `HCBP_ASSERT_NEXT(a_load_not_busy, clock, reset, accept && (req_func == hcbp_pkg::FUNC_LOAD), !busy, "load left the block busy")

endmodule

>>> tb/hcbp_byte_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Huffman code bit packer byte checker
// Watches the command and result channels of the packer, keeps its own code
// table and bit accumulator, and compares each result byte, field by field,
// with the oldest byte still expected. Mismatches are counted for the top.
// ---------------------------------------------------------------------------
module hcbp_byte_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [hcbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]  req_code_word,
   input  logic [hcbp_pkg::LEN_W-1:0]   req_code_length,
   input  logic                         rsp_valid,
   input  logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                         rsp_last,
   output int                           failures,
   output int                           outstanding,
   output int                           bytes_checked
);

   typedef struct packed {
      logic [hcbp_pkg::BYTE_W-1:0] data;
      logic                        last;
   } packed_byte_type;

   logic [hcbp_pkg::CODE_W-1:0] code_store   [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::LEN_W-1:0]  length_store [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::BYTE_W-1:0] pending_acc;
   int                          pending_count;
   packed_byte_type             expected_bytes [$];

   initial begin
      failures      = 0;
      outstanding   = 0;
      bytes_checked = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] byte check: %s", $time, msg);
      failures++;
   endtask

   // work out the bytes one command word gives and queue them
   task automatic pack_command(input logic [1:0]                  func,
                               input logic [hcbp_pkg::SYM_W-1:0]  sym,
                               input logic [hcbp_pkg::CODE_W-1:0] word,
                               input logic [hcbp_pkg::LEN_W-1:0]  len);
      logic [hcbp_pkg::LEN_W-1:0]  eff_len;
      logic [63:0]                 keep_mask;
      logic [hcbp_pkg::BYTE_W-1:0] padded;
      packed_byte_type             entry;
      int                          n_bytes;
      int                          emitted;
      case (func)
         hcbp_pkg::FUNC_LOAD: begin
            if (int'(sym) < hcbp_pkg::SYMBOL_COUNT) begin
               eff_len   = (int'(len) > hcbp_pkg::MAX_LEN) ?
                           hcbp_pkg::LEN_W'(hcbp_pkg::MAX_LEN) : len;
               keep_mask = (64'd1 << eff_len) - 64'd1;
               code_store[sym]   = word & keep_mask[hcbp_pkg::CODE_W-1:0];
               length_store[sym] = eff_len;
            end
         end
         hcbp_pkg::FUNC_ENCODE: begin
            if (int'(sym) < hcbp_pkg::SYMBOL_COUNT) begin
               n_bytes = (pending_count + int'(length_store[sym])) / hcbp_pkg::BYTE_W;
               emitted = 0;
               for (int b = int'(length_store[sym]) - 1; b >= 0; b--) begin
                  pending_acc = {pending_acc[hcbp_pkg::BYTE_W-2:0], code_store[sym][b]};
                  pending_count++;
                  if (pending_count == hcbp_pkg::BYTE_W) begin
                     emitted++;
                     entry.data = pending_acc;
                     entry.last = (emitted == n_bytes);
                     expected_bytes.push_back(entry);
                     pending_acc   = '0;
                     pending_count = 0;
                  end
               end
            end
         end
         hcbp_pkg::FUNC_FLUSH: begin
            if (pending_count != 0) begin
               padded     = pending_acc << (hcbp_pkg::BYTE_W - pending_count);
               entry.data = padded;
               entry.last = 1'b1;
               expected_bytes.push_back(entry);
               pending_acc   = '0;
               pending_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_byte(input logic [hcbp_pkg::BYTE_W-1:0] data, input logic last);
      packed_byte_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
      end else begin
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (data !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
         if (last !== want.last)
            report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                      last, data, want.last));
      end
   endtask

   // results first: a byte shown in the cycle a word is taken is never that word's
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hcbp_pkg::SYMBOL_COUNT; i++) begin
            code_store[i]   = '0;
            length_store[i] = '0;
         end
         pending_acc   = '0;
         pending_count = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid === 1'b1)
            check_byte(rsp_out_byte, rsp_last);
         if (start && busy === 1'b0)
            pack_command(req_func, req_symbol, req_code_word, req_code_length);
      end
      outstanding = expected_bytes.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Huffman code bit packer testbench
// Drives load, encode and flush words into the packer, first a directed set
// of corner cases and then a random mix weighted towards encodes of loaded
// symbols, with the sender idling at several rates. A checker beside the
// block predicts every byte; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;

   // func value with no meaning; the block must ignore the word
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 190;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        start           = 1'b0;
   logic [1:0]                  req_func        = hcbp_pkg::FUNC_LOAD;
   logic [hcbp_pkg::SYM_W-1:0]  req_symbol      = '0;
   logic [hcbp_pkg::CODE_W-1:0] req_code_word   = '0;
   logic [hcbp_pkg::LEN_W-1:0]  req_code_length = '0;
   logic                        busy;
   logic                        rsp_valid;
   logic [hcbp_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                        rsp_last;

   int failures;
   int outstanding;
   int bytes_checked;

   // sender idle chance per cycle, in percent
   int idle_pct = 10;
   int n_loads    = 0;
   int n_encodes  = 0;
   int n_flushes  = 0;
   int n_ignored  = 0;
   int stall_cycles = 0;

   // symbols with a loaded entry; only these may be encoded
   logic [hcbp_pkg::SYM_W-1:0] loaded_syms [$];
   bit                         sym_loaded  [hcbp_pkg::SYMBOL_COUNT];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   huffman_code_bit_packer u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   hcbp_byte_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .failures        (failures),
      .outstanding     (outstanding),
      .bytes_checked   (bytes_checked)
   );

   // Present one word from a falling edge, idling first at the current rate.
   // Hold it until a rising edge sees busy low, then return at the next
   // falling edge with start still high, so back-to-back words never lower
   // and raise start in the same step.
   task automatic send_word(input logic [1:0]                  func,
                            input logic [hcbp_pkg::SYM_W-1:0]  sym,
                            input logic [hcbp_pkg::CODE_W-1:0] word,
                            input logic [hcbp_pkg::LEN_W-1:0]  len);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_symbol      <= sym;
      req_code_word   <= word;
      req_code_length <= len;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      case (func)
         hcbp_pkg::FUNC_LOAD: begin
            n_loads++;
            if (!sym_loaded[sym]) begin
               sym_loaded[sym] = 1'b1;
               loaded_syms.push_back(sym);
            end
         end
         hcbp_pkg::FUNC_ENCODE: n_encodes++;
         hcbp_pkg::FUNC_FLUSH:  n_flushes++;
         default:               n_ignored++;
      endcase
      @(negedge clock);
   endtask

   // drop start and hold off until every expected byte has arrived
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // end the run if nothing moves on either channel for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && busy === 1'b0) || rsp_valid === 1'b1)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("[%0t] watchdog: no traffic for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int                         counted;
      int                         pick;
      logic [hcbp_pkg::SYM_W-1:0] sym;
      logic [hcbp_pkg::LEN_W-1:0] len;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // flush straight after reset: nothing pending, no byte
      send_word(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
      // unused func with every field bit set: ignored
      send_word(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      // longest codes, all ones and all zeros, at both ends of the symbol range
      send_word(hcbp_pkg::FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
      send_word(hcbp_pkg::FUNC_LOAD, 8'hFF, 32'h0000_0000, 6'd32);
      // zero-length code
      send_word(hcbp_pkg::FUNC_LOAD, 8'h01, 32'hDEAD_BEEF, 6'd0);
      // over-long lengths saturate to the longest code
      send_word(hcbp_pkg::FUNC_LOAD, 8'h02, 32'hA5A5_A5A5, 6'd63);
      send_word(hcbp_pkg::FUNC_LOAD, 8'h04, 32'h1234_5678, 6'd33);
      // word bits above the length are dropped
      send_word(hcbp_pkg::FUNC_LOAD, 8'h03, 32'hFFFF_FFFE, 6'd1);
      send_word(hcbp_pkg::FUNC_LOAD, 8'h80, 32'hFFFF_FFFD, 6'd3);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h01, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h03, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
      // three pending bits, then a 32-bit code straddling four byte boundaries
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h80, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h01, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'hFF, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h02, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h04, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
      // overwrite a loaded entry and use the new code
      send_word(hcbp_pkg::FUNC_LOAD, 8'h00, 32'h0000_0001, 6'd1);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_ENCODE, 8'h80, 32'h0, 6'd0);
      send_word(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0);

      // hold the sender until the packer has caught up
      wait_drained();

      // --- random part: mostly encodes of loaded symbols ---
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         // three idling phases: light, heavy, none
         if (counted < RANDOM_WORDS / 3)
            idle_pct = 10;
         else if (counted < 2 * RANDOM_WORDS / 3)
            idle_pct = 58;
         else
            idle_pct = 0;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            sym = hcbp_pkg::SYM_W'($urandom_range(0, hcbp_pkg::SYMBOL_COUNT - 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
               len = hcbp_pkg::LEN_W'($urandom_range(1, 12));
            else if (pick < 9)
               len = hcbp_pkg::LEN_W'($urandom_range(13, 32));
            else
               len = hcbp_pkg::LEN_W'($urandom_range(0, 63));
            send_word(hcbp_pkg::FUNC_LOAD, sym, $urandom, len);
            counted++;
         end else if (pick < 80) begin
            sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            send_word(hcbp_pkg::FUNC_ENCODE, sym, $urandom,
                      hcbp_pkg::LEN_W'($urandom_range(0, 63)));
            counted++;
         end else if (pick < 95) begin
            send_word(hcbp_pkg::FUNC_FLUSH, hcbp_pkg::SYM_W'($urandom_range(0, 255)),
                      $urandom, hcbp_pkg::LEN_W'($urandom_range(0, 63)));
            counted++;
         end else begin
            send_word(FUNC_UNUSED, hcbp_pkg::SYM_W'($urandom_range(0, 255)),
                      $urandom, hcbp_pkg::LEN_W'($urandom_range(0, 63)));
         end
         // now and then let the result channel drain fully mid-stream
         if ($urandom_range(0, 99) < 2)
            wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored words;",
               n_loads, n_encodes, n_flushes, n_ignored);
      $display("%0d result bytes compared over %0d loaded symbols.",
               bytes_checked, loaded_syms.size());
      if (failures == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
